>>> rtl/ordered_list_insert_delete_search_macros.svh
// assertion macros shared by the ordered list checker
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// same-cycle implication
`define OLIST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLIST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/olist_pkg.sv
// shared types and constants of the ordered list store
// no dependencies
`default_nettype none

package olist_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int FIDX_W     = 4;
  localparam int CNT_OUT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // request broadcast to every cell during a sweep
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // token walking down the row of cells
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DATA_W-1:0] carry;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/olist_cell.sv
// one storage cell of the ordered list row
// depends on olist_pkg
`default_nettype none

module olist_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX      = 0
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  olist_pkg::req_t                          req,
  input  wire [$clog2(CAPACITY)-1:0]               ins_pos,
  input  wire [$clog2(CAPACITY+1)-1:0]             count,
  input  olist_pkg::tok_t                          tok_in,
  input  wire signed [olist_pkg::DATA_W-1:0]       right_val,
  output olist_pkg::tok_t                          tok_out,
  output logic signed [olist_pkg::DATA_W-1:0]      val_out
);
  import olist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  tok_t                     tok_r;
  logic                     in_use, at_pos, match, hit;

  assign in_use  = CW'(IDX) < count;
  assign at_pos  = IW'(IDX) == ins_pos;
  assign match   = in_use && (val_r == req.value);
  assign hit     = tok_r.found || match;
  assign val_out = val_r;

  always_comb begin
    val_nxt = val_r;
    tok_out = tok_r;
    if (tok_r.valid) begin
      unique case (req.op)
        OP_INSERT, OP_APPEND: begin
          // shift up behind the insertion point
          if (tok_r.found) begin
            val_nxt       = tok_r.carry;
            tok_out.carry = val_r;
          end else if (at_pos) begin
            val_nxt       = req.value;
            tok_out.carry = val_r;
            tok_out.found = 1'b1;
          end
        end
        OP_DELETE: begin
          // from the first match on, pull the right neighbor in
          if (hit) begin
            val_nxt = right_val;
          end
          tok_out.found = hit;
        end
        OP_SEARCH: begin
          if (match && !tok_r.found) begin
            tok_out.found = 1'b1;
            tok_out.carry = DATA_W'(IDX);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/ordered_list_insert_delete_search.sv
// top level of the ordered list store: request control and the row of cells
// depends on olist_pkg and olist_cell
`default_nettype none

// ordered list of up to CAPACITY signed 32-bit words, entry 0 at the head
// input channel: in_operation, in_value, in_position are taken at a rising
//   edge where start is high and busy is low
// result channel: out_status, out_found_index, out_item_count are valid for
//   exactly one cycle while out_valid is high; the receiver cannot stall
// insert or append into a full list, or insert past the end: the result
//   shows in the cycle after the request, busy never rises, a new word can
//   follow every cycle
// every other request sends a token down the row of CAPACITY cells, one cell
//   per cycle, each cell comparing and shifting its own entry; the result
//   shows once the token has left the last cell, and busy stays high until
//   then, so no new word is taken while the token is in the row
// the next request may be given in the cycle its predecessor's result shows
// reset clears the entry count and any sweep in flight; entries themselves
//   are not cleared, only those below the count take part in a match
module ordered_list_insert_delete_search #(
  parameter int CAPACITY = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire [olist_pkg::OP_W-1:0]             in_operation,
  input  wire signed [olist_pkg::DATA_W-1:0]    in_value,
  input  wire [olist_pkg::POS_W-1:0]            in_position,
  output logic                                  out_valid,
  output logic [olist_pkg::STATUS_W-1:0]        out_status,
  output logic [olist_pkg::FIDX_W-1:0]          out_found_index,
  output logic [olist_pkg::CNT_OUT_W-1:0]       out_item_count
);
  import olist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // request and list state
  logic              busy_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  req_t              req_r;
  logic [IW-1:0]     pos_r;

  // result registers
  logic              out_valid_r;
  status_t           out_status_r, status_nxt;
  logic [FIDX_W-1:0] out_fidx_r, fidx_nxt;
  logic [CW-1:0]     out_cnt_r;

  // row links
  tok_t                     tok_link [CAPACITY+1];
  logic signed [DATA_W-1:0] val_link [CAPACITY];

  op_t   in_op;
  logic  accept, full, bad_pos, reject, sweep_done;
  tok_t  end_tok;
  tok_t  head_tok;

  assign in_op   = op_t'(in_operation);
  assign accept  = start && !busy_r;
  assign full    = cnt_r == CW'(CAPACITY);
  assign bad_pos = 32'(in_position) > 32'(cnt_r);

  // requests that finish without a sweep
  always_comb begin
    reject     = 1'b0;
    status_nxt = ST_OK;
    unique case (in_op)
      OP_INSERT: begin
        if (full) begin
          reject     = 1'b1;
          status_nxt = ST_FULL;
        end else if (bad_pos) begin
          reject     = 1'b1;
          status_nxt = ST_BAD_POS;
        end
      end
      OP_APPEND: begin
        if (full) begin
          reject     = 1'b1;
          status_nxt = ST_FULL;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        reject = 1'b0;
      end
    endcase
  end

  // token injected into the head cell
  always_comb begin
    head_tok       = '0;
    head_tok.valid = accept && !reject;
  end
  assign tok_link[0] = head_tok;

  assign end_tok    = tok_link[CAPACITY];
  assign sweep_done = end_tok.valid;

  // outcome of a finished sweep
  status_t       sweep_status;
  logic [FIDX_W-1:0] sweep_fidx;
  always_comb begin
    sweep_status = ST_OK;
    sweep_fidx   = '0;
    cnt_nxt      = cnt_r;
    case (req_r.op)
      OP_INSERT, OP_APPEND: begin
        cnt_nxt = cnt_r + CW'(1);
      end
      OP_DELETE: begin
        if (end_tok.found) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          sweep_status = ST_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        if (end_tok.found) begin
          sweep_fidx = FIDX_W'(end_tok.carry);
        end else begin
          sweep_status = ST_NOT_FOUND;
        end
      end
    endcase
  end
  assign fidx_nxt = sweep_fidx;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= sweep_done || (accept && reject);
      if (sweep_done) begin
        busy_r <= 1'b0;
        cnt_r  <= cnt_nxt;
      end else if (accept && !reject) begin
        busy_r <= 1'b1;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept && !reject) begin
      req_r.op    <= in_op;
      req_r.value <= in_value;
      // append lands at the tail
      pos_r       <= (in_op == OP_APPEND) ? IW'(cnt_r) : IW'(in_position);
    end
    if (sweep_done) begin
      out_status_r <= sweep_status;
      out_fidx_r   <= fidx_nxt;
      out_cnt_r    <= cnt_nxt;
    end else if (accept && reject) begin
      out_status_r <= status_nxt;
      out_fidx_r   <= '0;
      out_cnt_r    <= cnt_r;
    end
  end

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] right_val;
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = val_link[i];
    end else begin : g_mid
      assign right_val = val_link[i+1];
    end
    olist_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req_r),
      .ins_pos   (pos_r),
      .count     (cnt_r),
      .tok_in    (tok_link[i]),
      .right_val (right_val),
      .tok_out   (tok_link[i+1]),
      .val_out   (val_link[i])
    );
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_fidx_r;
  assign out_item_count  = CNT_OUT_W'(out_cnt_r);

endmodule

`default_nettype wire

>>> rtl/olist_checker.sv
// port-level checks for the ordered list store, bound to its top level
// depends on olist_pkg and the assertion macro header
`default_nettype none
`include "ordered_list_insert_delete_search_macros.svh"

module olist_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input wire                                out_valid,
  input wire [olist_pkg::STATUS_W-1:0]      out_status,
  input wire [olist_pkg::FIDX_W-1:0]        out_found_index
);
  import olist_pkg::*;

  // a word is shown only once the sweep has let go of busy
  `OLIST_ASSERT_IMP(a_valid_not_busy, out_valid, !busy, "result shown while busy")
  // a failed request reports index zero
  `OLIST_ASSERT_IMP(a_fail_idx_zero, out_valid && (out_status != ST_OK), out_found_index == '0, "index set on failed request")
  // busy only drops together with a result
  `OLIST_ASSERT_NXT(a_busy_ends_in_result, busy, busy || out_valid, "busy dropped without a result")
  // no result appears without a request
  `OLIST_ASSERT_NXT(a_no_spurious_result, !busy && !start, !out_valid, "result without a request")

endmodule

bind ordered_list_insert_delete_search olist_checker u_olist_checker (.*);

`default_nettype wire
